### rtl/core/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Depends on nothing; every module of the queue imports it.
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;

    // Operation codes carried in the opcode field.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Status codes returned with every result.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                      opcode;
        logic signed [VALUE_W-1:0] item_value;
        logic signed [PRIO_W-1:0]  item_priority;
    } spq_in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        entry_count;
    } spq_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } spq_ctrl_t;

endpackage

### rtl/core/spq_ctrl.sv
// Controller of the sorted priority queue: sequences load and execute.
// Depends on spq_pkg for the command struct.
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output spq_pkg::spq_ctrl_t ctrl
);
    import spq_pkg::*;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    state_next = EXEC;
                end
            end
            EXEC:
            begin
                state_next = IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy      = (state_reg == EXEC);
    assign ctrl.load = start && (state_reg == IDLE);
    assign ctrl.exec = (state_reg == EXEC);
    assign done      = done_reg;

endmodule

### rtl/core/spq_datapath.sv
// Datapath of the sorted priority queue: a row of sorted cells with shift logic.
// Depends on spq_pkg for the item, result and command types.
module spq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  spq_pkg::spq_in_t   cmd,
    output spq_pkg::spq_out_t  result
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    spq_in_t                   cmd_reg;
    logic signed [VALUE_W-1:0] val_reg  [DEPTH];
    logic signed [PRIO_W-1:0]  prio_reg [DEPTH];
    logic signed [VALUE_W-1:0] val_next [DEPTH];
    logic signed [PRIO_W-1:0]  prio_next[DEPTH];
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW+COUNT_W-1:0]     count_wide;
    logic [DEPTH-1:0]          goes_after;
    logic                      full;
    logic                      empty;
    spq_out_t                  result_reg;
    spq_out_t                  result_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // A cell is flagged when the new entry belongs at or before it. The head
    // only yields to a strictly smaller priority number; later cells yield on equal.
    // Empty cells are always flagged, so the flags form a suffix of the row.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CW'(i) >= count_reg)
            begin
                goes_after[i] = 1'b1;
            end
            else if (i == 0)
            begin
                goes_after[i] = (prio_reg[i] > cmd_reg.item_priority);
            end
            else
            begin
                goes_after[i] = (prio_reg[i] >= cmd_reg.item_priority);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            val_next[i]  = val_reg[i];
            prio_next[i] = prio_reg[i];
        end
        count_next               = count_reg;
        result_next.popped_value = '0;
        result_next.status       = ST_DONE;

        if (cmd_reg.opcode == OP_ENQUEUE)
        begin
            if (full)
            begin
                result_next.status = ST_FULL;
            end
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (i > 0 && goes_after[(i > 0) ? i - 1 : 0])
                    begin
                        val_next[i]  = val_reg[(i > 0) ? i - 1 : 0];
                        prio_next[i] = prio_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (goes_after[i])
                    begin
                        val_next[i]  = cmd_reg.item_value;
                        prio_next[i] = cmd_reg.item_priority;
                    end
                end
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.popped_value = val_reg[0];
                for (int i = 0; i < DEPTH - 1; i++)
                begin
                    val_next[i]  = val_reg[i + 1];
                    prio_next[i] = prio_reg[i + 1];
                end
                count_next = count_reg - 1'b1;
            end
        end

        count_wide              = (CW + COUNT_W)'(count_next);
        result_next.entry_count = count_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
        end
        if (ctrl.exec)
        begin
            result_reg <= result_next;
            for (int i = 0; i < DEPTH; i++)
            begin
                val_reg[i]  <= val_next[i];
                prio_reg[i] <= prio_next[i];
            end
        end
    end

    assign result = result_reg;

endmodule

### rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue, smallest priority number first.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage:
//   A command transfer happens at a rising edge where start is high and busy
//   is low. The cmd struct carries the opcode (enqueue or dequeue), the data
//   word and the signed priority; data and priority are ignored on dequeue.
//   Every command yields exactly one result transfer: done is high for one
//   cycle and the result struct holds the popped data word (zero unless a
//   dequeue succeeded), the status code and the number of entries held.
//   Sequence: the command is latched on the accepting edge, the cell row
//   updates on the next edge, and done is high in the cycle after that.
//   busy is high while the controller is in its execute state, so a new
//   command is taken only after the last one has executed.
//   Every cell of the row compares against the new priority in parallel, so
//   the cost per command does not depend on DEPTH.
//   Reset clears the entry count and the controller; stored entries are not
//   cleared and are never read until written.
//   The receiver cannot stall: a result is valid only during its done cycle.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::spq_in_t  cmd,
    output logic              done,
    output spq_pkg::spq_out_t result
);
    import spq_pkg::*;

    spq_ctrl_t ctrl;

    // Controller: decides when a command is latched and when it executes.
    spq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // Datapath: the sorted cell row, entry count and result register.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cmd    (cmd),
        .result (result)
    );

endmodule
